@@ src/xzf_pkg.sv @@
package xzf_pkg;

   localparam int CHUNK_BYTES_DEFAULT = 4096;
   localparam int LENGTH_BITS_DEFAULT = 40;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_run;
      logic       stream_done;
      logic       length_error;
   } rsp_type;

   typedef struct packed {
      logic        operation;
      logic [7:0]  data_byte;
      logic        send_hdr;
      logic        accept;
      logic        chunk_hdr;
      logic        is_first;
      logic [15:0] hdr_size;
      logic        err;
      logic [63:0] bytes_seen;
      logic [63:0] chunks;
   } cmd_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   localparam logic [31:0] SH_CRC = ~crc_byte(crc_byte(CRC_INIT, 8'h00), 8'h01);
   localparam logic [31:0] BH_CRC = ~crc_byte(crc_byte(crc_byte(crc_byte(crc_byte(
      crc_byte(crc_byte(crc_byte(CRC_INIT, 8'h02), 8'h00), 8'h21), 8'h01), 8'h10),
      8'h00), 8'h00), 8'h00);

   function automatic logic [7:0] hdr_byte(input logic [4:0] idx);
      logic [7:0] r;
      unique case (idx)
         5'd0:    r = 8'hFD;
         5'd1:    r = 8'h37;
         5'd2:    r = 8'h7A;
         5'd3:    r = 8'h58;
         5'd4:    r = 8'h5A;
         5'd7:    r = 8'h01;
         5'd8:    r = SH_CRC[7:0];
         5'd9:    r = SH_CRC[15:8];
         5'd10:   r = SH_CRC[23:16];
         5'd11:   r = SH_CRC[31:24];
         5'd12:   r = 8'h02;
         5'd14:   r = 8'h21;
         5'd15:   r = 8'h01;
         5'd16:   r = 8'h10;
         5'd20:   r = BH_CRC[7:0];
         5'd21:   r = BH_CRC[15:8];
         5'd22:   r = BH_CRC[23:16];
         5'd23:   r = BH_CRC[31:24];
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

@@ src/xzf_front.sv @@
module xzf_front #(
   parameter int CHUNK_BYTES = xzf_pkg::CHUNK_BYTES_DEFAULT,
   parameter int LENGTH_BITS = xzf_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [LENGTH_BITS-1:0] stream_length,
   input  logic                   req_push,
   input  xzf_pkg::req_type       req_data,
   output logic                   req_full,
   input  logic                   q_full,
   output logic                   q_push,
   output xzf_pkg::cmd_type       q_data
);
   import xzf_pkg::*;

   localparam int FILL_BITS = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

   logic [LENGTH_BITS-1:0] bytes_ff, bytes_in, chunks_ff, chunks_in, rem;
   logic [FILL_BITS-1:0]   fill_ff, fill_in;
   logic                   hdr_ff, hdr_in, drop_ff, drop_in;
   logic                   take, accept, chunk;
   logic [FILL_BITS:0]     fill_nx;

   assign req_full = q_full;
   assign take     = req_push && !q_full;
   assign accept   = bytes_ff < stream_length;
   assign chunk    = accept && (fill_ff == '0);
   assign rem      = stream_length - bytes_ff;
   assign fill_nx  = {1'b0, fill_ff} + (FILL_BITS+1)'(1);

   always_comb begin
      q_data.operation   = req_data.operation;
      q_data.data_byte   = req_data.data_byte;
      q_data.send_hdr    = !hdr_ff;
      q_data.accept      = accept;
      q_data.chunk_hdr   = chunk;
      q_data.is_first    = (chunks_ff == '0);
      q_data.hdr_size    = ({1'b0, rem} < (LENGTH_BITS+1)'(CHUNK_BYTES)) ?
                           16'(rem - LENGTH_BITS'(1)) : 16'(CHUNK_BYTES - 1);
      q_data.bytes_seen  = 64'(bytes_ff);
      q_data.chunks      = 64'(chunks_ff);
      if (req_data.operation == OP_END) begin
         q_data.err = drop_ff || (bytes_ff != stream_length);
      end else begin
         q_data.err = drop_ff || !accept;
      end
      q_push = take && ((req_data.operation == OP_END) || accept || !hdr_ff);

      bytes_in  = bytes_ff;
      chunks_in = chunks_ff;
      fill_in   = fill_ff;
      hdr_in    = hdr_ff;
      drop_in   = drop_ff;
      if (take) begin
         if (req_data.operation == OP_END) begin
            bytes_in  = '0;
            chunks_in = '0;
            fill_in   = '0;
            hdr_in    = 1'b0;
            drop_in   = 1'b0;
         end else begin
            hdr_in = 1'b1;
            if (accept) begin
               bytes_in = bytes_ff + LENGTH_BITS'(1);
               fill_in  = (fill_nx == (FILL_BITS+1)'(CHUNK_BYTES)) ? '0 :
                          fill_nx[FILL_BITS-1:0];
               if (chunk) begin
                  chunks_in = chunks_ff + LENGTH_BITS'(1);
               end
            end else begin
               drop_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff  <= '0;
         chunks_ff <= '0;
         fill_ff   <= '0;
         hdr_ff    <= 1'b0;
         drop_ff   <= 1'b0;
      end else begin
         bytes_ff  <= bytes_in;
         chunks_ff <= chunks_in;
         fill_ff   <= fill_in;
         hdr_ff    <= hdr_in;
         drop_ff   <= drop_in;
      end
   end

endmodule

@@ src/xzf_queue.sv @@
module xzf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  xzf_pkg::cmd_type wdata,
   output logic             full,
   input  logic             pop,
   output xzf_pkg::cmd_type rdata,
   output logic             valid
);
   import xzf_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign rdata = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wdata;
      end
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

@@ src/xzf_back.sv @@
module xzf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  xzf_pkg::cmd_type q_head,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output xzf_pkg::rsp_type rsp_data
);
   import xzf_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_HDR   = 4'd1;
   localparam logic [3:0] ST_CHDR  = 4'd2;
   localparam logic [3:0] ST_DATA  = 4'd3;
   localparam logic [3:0] ST_SETUP = 4'd4;
   localparam logic [3:0] ST_MARK  = 4'd5;
   localparam logic [3:0] ST_PAD   = 4'd6;
   localparam logic [3:0] ST_DCRC  = 4'd7;
   localparam logic [3:0] ST_IDX   = 4'd8;
   localparam logic [3:0] ST_VLIA  = 4'd9;
   localparam logic [3:0] ST_VLIB  = 4'd10;
   localparam logic [3:0] ST_IPAD  = 4'd11;
   localparam logic [3:0] ST_ICRC  = 4'd12;
   localparam logic [3:0] ST_FCRC  = 4'd13;
   localparam logic [3:0] ST_FOOT  = 4'd14;

   localparam logic [4:0] HDR_LAST  = 5'd23;
   localparam logic [4:0] FOOT_LAST = 5'd9;

   logic [3:0]  st_ff, st_in;
   logic [4:0]  pos_ff, pos_in, idx_ff, idx_in, idx_nx;
   logic [1:0]  pad_ff, pad_in;
   logic [31:0] dcrc_ff, dcrc_in, tcrc_ff, tcrc_in, fcrc_ff, fcrc_in, backward;
   logic [63:0] unp_ff, unp_in, vli_ff, vli_in;
   cmd_type     cmd_ff, cmd_in;
   rsp_type     out_ff;
   logic        out_valid_ff, can_emit, emit, finish, vli_last;
   logic [7:0]  ebyte, vbyte, ft;
   logic        elast, edone;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign can_emit  = !out_valid_ff || rsp_pop;
   assign idx_nx    = idx_ff + 5'd1;
   assign backward  = {29'h0, idx_ff[4:2]};
   assign vbyte     = {|vli_ff[63:7], vli_ff[6:0]};
   assign vli_last  = ~|vli_ff[63:7];

   function automatic logic [3:0] start_of(input cmd_type c);
      logic [3:0] s;
      if (c.send_hdr) begin
         s = ST_HDR;
      end else if (c.operation == OP_END) begin
         s = ST_SETUP;
      end else if (c.chunk_hdr) begin
         s = ST_CHDR;
      end else begin
         s = ST_DATA;
      end
      return s;
   endfunction

   always_comb begin
      unique case (pos_ff[2:0])
         3'd0:    ft = backward[7:0];
         3'd1:    ft = backward[15:8];
         3'd2:    ft = backward[23:16];
         3'd3:    ft = backward[31:24];
         3'd5:    ft = 8'h01;
         default: ft = 8'h00;
      endcase
   end

   always_comb begin
      st_in   = st_ff;
      pos_in  = pos_ff;
      idx_in  = idx_ff;
      pad_in  = pad_ff;
      dcrc_in = dcrc_ff;
      tcrc_in = tcrc_ff;
      fcrc_in = fcrc_ff;
      unp_in  = unp_ff;
      vli_in  = vli_ff;
      cmd_in  = cmd_ff;
      emit    = 1'b0;
      ebyte   = 8'h00;
      elast   = 1'b0;
      edone   = 1'b0;
      finish  = 1'b0;
      q_pop   = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            finish = 1'b1;
         end
         ST_HDR: begin
            emit  = 1'b1;
            ebyte = hdr_byte(pos_ff);
            elast = (pos_ff == HDR_LAST) && (cmd_ff.operation == OP_DATA) &&
                    !cmd_ff.accept;
            if (can_emit) begin
               pos_in = pos_ff + 5'd1;
               if (pos_ff == HDR_LAST) begin
                  pos_in = '0;
                  if (cmd_ff.operation == OP_END) begin
                     st_in = ST_SETUP;
                  end else if (!cmd_ff.accept) begin
                     finish = 1'b1;
                  end else if (cmd_ff.chunk_hdr) begin
                     st_in = ST_CHDR;
                  end else begin
                     st_in = ST_DATA;
                  end
               end
            end
         end
         ST_CHDR: begin
            emit = 1'b1;
            unique case (pos_ff[1:0])
               2'd0:    ebyte = cmd_ff.is_first ? 8'h01 : 8'h02;
               2'd1:    ebyte = cmd_ff.hdr_size[15:8];
               default: ebyte = cmd_ff.hdr_size[7:0];
            endcase
            if (can_emit) begin
               pos_in = pos_ff + 5'd1;
               if (pos_ff == 5'd2) begin
                  pos_in = '0;
                  st_in  = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            emit  = 1'b1;
            ebyte = cmd_ff.data_byte;
            elast = 1'b1;
            if (can_emit) begin
               dcrc_in = crc_byte(dcrc_ff, cmd_ff.data_byte);
               finish  = 1'b1;
            end
         end
         ST_SETUP: begin
            unp_in = (cmd_ff.chunks << 1) + cmd_ff.chunks + cmd_ff.bytes_seen + 64'd17;
            st_in  = ST_MARK;
         end
         ST_MARK: begin
            emit   = 1'b1;
            pad_in = 2'(~unp_ff[1:0] + 2'd1);
            if (can_emit) begin
               st_in = (pad_in != 2'd0) ? ST_PAD : ST_DCRC;
            end
         end
         ST_PAD: begin
            emit = 1'b1;
            if (can_emit) begin
               pad_in = pad_ff - 2'd1;
               if (pad_ff == 2'd1) begin
                  st_in = ST_DCRC;
               end
            end
         end
         ST_DCRC: begin
            emit  = 1'b1;
            ebyte = ~dcrc_ff[8*pos_ff[1:0] +: 8];
            if (can_emit) begin
               pos_in = pos_ff + 5'd1;
               if (pos_ff == 5'd3) begin
                  pos_in  = '0;
                  idx_in  = '0;
                  tcrc_in = CRC_INIT;
                  st_in   = ST_IDX;
               end
            end
         end
         ST_IDX: begin
            emit  = 1'b1;
            ebyte = {7'h0, pos_ff[0]};
            if (can_emit) begin
               tcrc_in = crc_byte(tcrc_ff, ebyte);
               idx_in  = idx_nx;
               pos_in  = pos_ff + 5'd1;
               if (pos_ff == 5'd1) begin
                  pos_in = '0;
                  vli_in = unp_ff;
                  st_in  = ST_VLIA;
               end
            end
         end
         ST_VLIA, ST_VLIB: begin
            emit  = 1'b1;
            ebyte = vbyte;
            if (can_emit) begin
               tcrc_in = crc_byte(tcrc_ff, ebyte);
               idx_in  = idx_nx;
               vli_in  = vli_ff >> 7;
               if (vli_last) begin
                  if (st_ff == ST_VLIA) begin
                     vli_in = cmd_ff.bytes_seen;
                     st_in  = ST_VLIB;
                  end else begin
                     st_in = (idx_nx[1:0] != 2'd0) ? ST_IPAD : ST_ICRC;
                  end
               end
            end
         end
         ST_IPAD: begin
            emit = 1'b1;
            if (can_emit) begin
               tcrc_in = crc_byte(tcrc_ff, 8'h00);
               idx_in  = idx_nx;
               if (idx_nx[1:0] == 2'd0) begin
                  st_in = ST_ICRC;
               end
            end
         end
         ST_ICRC: begin
            emit  = 1'b1;
            ebyte = ~tcrc_ff[8*pos_ff[1:0] +: 8];
            if (can_emit) begin
               pos_in = pos_ff + 5'd1;
               if (pos_ff == 5'd3) begin
                  pos_in  = '0;
                  fcrc_in = CRC_INIT;
                  st_in   = ST_FCRC;
               end
            end
         end
         ST_FCRC: begin
            fcrc_in = crc_byte(fcrc_ff, ft);
            pos_in  = pos_ff + 5'd1;
            if (pos_ff == 5'd5) begin
               pos_in = '0;
               st_in  = ST_FOOT;
            end
         end
         ST_FOOT: begin
            emit = 1'b1;
            unique case (pos_ff[3:0])
               4'd0:    ebyte = ~fcrc_ff[7:0];
               4'd1:    ebyte = ~fcrc_ff[15:8];
               4'd2:    ebyte = ~fcrc_ff[23:16];
               4'd3:    ebyte = ~fcrc_ff[31:24];
               4'd4:    ebyte = backward[7:0];
               4'd5:    ebyte = backward[15:8];
               4'd6:    ebyte = backward[23:16];
               4'd7:    ebyte = backward[31:24];
               4'd9:    ebyte = 8'h01;
               4'd10:   ebyte = 8'h59;
               4'd11:   ebyte = 8'h5A;
               default: ebyte = 8'h00;
            endcase
            elast = (pos_ff == FOOT_LAST + 5'd2);
            edone = elast;
            if (can_emit) begin
               pos_in = pos_ff + 5'd1;
               if (elast) begin
                  pos_in  = '0;
                  dcrc_in = CRC_INIT;
                  finish  = 1'b1;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         st_in  = ST_IDLE;
         pos_in = '0;
         if (q_valid) begin
            q_pop  = 1'b1;
            cmd_in = q_head;
            st_in  = start_of(q_head);
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      idx_ff  <= idx_in;
      pad_ff  <= pad_in;
      tcrc_ff <= tcrc_in;
      fcrc_ff <= fcrc_in;
      unp_ff  <= unp_in;
      vli_ff  <= vli_in;
      cmd_ff  <= cmd_in;
      if (emit && can_emit) begin
         out_ff.out_byte     <= ebyte;
         out_ff.end_of_run   <= elast;
         out_ff.stream_done  <= edone;
         out_ff.length_error <= cmd_ff.err;
      end
      if (reset) begin
         st_ff        <= ST_IDLE;
         dcrc_ff      <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         dcrc_ff <= dcrc_in;
         if (emit && can_emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ src/xz_stored_stream_framer_core.sv @@
// channel   direction  handshake               payload
// req_      in         push / full             req_type  (operation, data_byte)
// rsp_      out        pop / empty             rsp_type  (out_byte, flags)
// csr_      in         psel/penable/pwrite     LENGTH_BITS-wide stream_length at 0x0
//
// The output sequencer sends at most one byte per cycle and holds while the
// result side is stalled; a data byte in an open chunk is one byte, a chunk
// header adds three, the first item 24 header bytes. An end item also runs
// silent steps (size sum and footer check). Synchronous active-high reset
// empties the command queue and the output register. A stalled result side
// backs up into the two-word command queue, after which full rises.
module xz_stored_stream_framer_core #(
   parameter int CHUNK_BYTES = xzf_pkg::CHUNK_BYTES_DEFAULT,
   parameter int LENGTH_BITS = xzf_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  xzf_pkg::req_type req_data,
   output logic             req_full,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output xzf_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [63:0]      csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);
   import xzf_pkg::*;

   logic [LENGTH_BITS-1:0] length_ff;
   logic                   q_full, q_push, q_pop, q_valid;
   cmd_type                q_wdata, q_rdata;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[3] ? 64'h0 : 64'(length_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[3]) begin
         length_ff <= csr_pwdata[LENGTH_BITS-1:0];
      end
   end

   xzf_front #(
      .CHUNK_BYTES (CHUNK_BYTES),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .stream_length (length_ff),
      .req_push      (req_push),
      .req_data      (req_data),
      .req_full      (req_full),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_wdata)
   );

   xzf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .valid (q_valid)
   );

   xzf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_rdata),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

@@ src/xzf_checker.sv @@
module xzf_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_pop,
   input logic             rsp_empty,
   input xzf_pkg::rsp_type rsp_data
);
   import xzf_pkg::*;

   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present after reset");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.stream_done |-> rsp_data.end_of_run)
      else $error("stream end not on last word of run");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("waiting word vanished");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_data))
      else $error("waiting word changed");

endmodule

bind xz_stored_stream_framer_core xzf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_pop   (rsp_pop),
   .rsp_empty (rsp_empty),
   .rsp_data  (rsp_data)
);

@@ tb/sv/tb_xz_stored_stream_framer_core.sv @@
module tb_xz_stored_stream_framer_core;
   import xzf_pkg::*;

   localparam int CHUNK = 4096;
   localparam logic [3:0] ADDR_STREAM_LENGTH = 4'h0;
   localparam int CYCLE_LIMIT = 2000000;

   logic        clock;
   logic        reset;
   logic        req_push;
   req_type     req_data;
   logic        req_full;
   logic        rsp_pop;
   logic        rsp_empty;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   xz_stored_stream_framer_core i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   req_type pending_words[$];
   rsp_type framed_bytes[$];
   int      send_idle_pct;
   int      recv_idle_pct;
   int      errors;
   int      cycles;

   // framer state
   logic [39:0] stream_len;
   logic [31:0] data_crc;
   logic [39:0] bytes_seen;
   int          chunk_fill;
   logic [39:0] chunks_sent;
   logic        hdr_sent;
   logic        dropped;
   logic [31:0] idx_check;
   int          index_len;
   logic        err_now;

   function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h0, b};
      for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
      return r;
   endfunction

   function automatic void emit(logic [7:0] b);
      rsp_type r;
      r.out_byte = b;
      r.end_of_run = 1'b0;
      r.stream_done = 1'b0;
      r.length_error = err_now;
      framed_bytes.push_back(r);
   endfunction

   function automatic void emit_le32(logic [31:0] v);
      for (int k = 0; k < 4; k++) emit(v[8*k +: 8]);
   endfunction

   function automatic void emit_index(logic [7:0] b);
      idx_check = crc_next(idx_check, b);
      emit(b);
      index_len++;
   endfunction

   function automatic void emit_vli(logic [63:0] v);
      logic [7:0] b;
      do begin
         b = {1'b0, v[6:0]};
         v = v >> 7;
         if (v != 0) b[7] = 1'b1;
         emit_index(b);
      end while (v != 0);
   endfunction

   function automatic void emit_headers();
      logic [7:0]  sh[8];
      logic [7:0]  bh[8];
      logic [31:0] c;
      sh = '{8'hfd, 8'h37, 8'h7a, 8'h58, 8'h5a, 8'h00, 8'h00, 8'h01};
      bh = '{8'h02, 8'h00, 8'h21, 8'h01, 8'h10, 8'h00, 8'h00, 8'h00};
      for (int k = 0; k < 8; k++) emit(sh[k]);
      emit_le32(~crc_next(crc_next(32'hffffffff, sh[6]), sh[7]));
      c = 32'hffffffff;
      for (int k = 0; k < 8; k++) begin
         emit(bh[k]);
         c = crc_next(c, bh[k]);
      end
      emit_le32(~c);
      hdr_sent = 1'b1;
   endfunction

   function automatic void clear_stream();
      data_crc = 32'hffffffff;
      bytes_seen = '0;
      chunk_fill = 0;
      chunks_sent = '0;
      hdr_sent = 1'b0;
      dropped = 1'b0;
   endfunction

   function automatic void emit_trailer();
      logic [63:0] block_data;
      logic [63:0] unpadded;
      logic [31:0] backward;
      logic [31:0] c;
      logic [7:0]  ft[6];
      rsp_type     r;
      int          pad;
      emit(8'h00);
      block_data = 64'(chunks_sent) * 3 + 64'(bytes_seen) + 1;
      pad = (4 - int'((12 + block_data) % 4)) % 4;
      repeat (pad) emit(8'h00);
      emit_le32(~data_crc);
      unpadded = 12 + block_data + 4;
      index_len = 0;
      idx_check = 32'hffffffff;
      emit_index(8'h00);
      emit_vli(64'd1);
      emit_vli(unpadded);
      emit_vli(64'(bytes_seen));
      while (index_len % 4 != 0) emit_index(8'h00);
      emit_le32(~idx_check);
      backward = (index_len + 4) / 4 - 1;
      ft = '{backward[7:0], backward[15:8], backward[23:16], backward[31:24], 8'h00, 8'h01};
      c = 32'hffffffff;
      for (int k = 0; k < 6; k++) c = crc_next(c, ft[k]);
      emit_le32(~c);
      emit_le32(backward);
      emit(8'h00);
      emit(8'h01);
      emit(8'h59);
      emit(8'h5a);
      r = framed_bytes.pop_back();
      r.stream_done = 1'b1;
      framed_bytes.push_back(r);
   endfunction

   function automatic void frame_word(req_type w);
      int          start;
      logic [39:0] rem;
      logic [15:0] size;
      rsp_type     r;
      start = framed_bytes.size();
      if (w.operation == OP_DATA) begin
         if (bytes_seen >= stream_len) dropped = 1'b1;
         err_now = dropped;
         if (!hdr_sent) emit_headers();
         if (bytes_seen < stream_len) begin
            if (chunk_fill == 0) begin
               rem = stream_len - bytes_seen;
               size = (rem < CHUNK) ? 16'(rem - 1) : 16'(CHUNK - 1);
               emit(chunks_sent == 0 ? 8'h01 : 8'h02);
               emit(size[15:8]);
               emit(size[7:0]);
               chunks_sent++;
            end
            data_crc = crc_next(data_crc, w.data_byte);
            emit(w.data_byte);
            bytes_seen++;
            chunk_fill = (chunk_fill + 1) % CHUNK;
         end
      end else begin
         err_now = dropped || (bytes_seen != stream_len);
         if (!hdr_sent) emit_headers();
         emit_trailer();
         clear_stream();
      end
      if (framed_bytes.size() > start) begin
         r = framed_bytes.pop_back();
         r.end_of_run = 1'b1;
         framed_bytes.push_back(r);
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            frame_word(pending_words.pop_front());
         end
         if (!(req_push && req_full)) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_push <= 1'b1;
               req_data <= pending_words[0];
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (framed_bytes.size() == 0) begin
               $error("unexpected word %h", rsp_data);
               errors++;
            end else begin
               e = framed_bytes.pop_front();
               if (rsp_data.out_byte !== e.out_byte) begin
                  $error("out_byte expected %h actual %h", e.out_byte, rsp_data.out_byte);
                  errors++;
               end
               if (rsp_data.end_of_run !== e.end_of_run) begin
                  $error("end_of_run expected %b actual %b", e.end_of_run,
                         rsp_data.end_of_run);
                  errors++;
               end
               if (rsp_data.stream_done !== e.stream_done) begin
                  $error("stream_done expected %b actual %b", e.stream_done,
                         rsp_data.stream_done);
                  errors++;
               end
               if (rsp_data.length_error !== e.length_error) begin
                  $error("length_error expected %b actual %b", e.length_error,
                         rsp_data.length_error);
                  errors++;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_xz_stored_stream_framer_core: done, errors");
         $finish;
      end
   end

   task automatic wait_idle();
      while (pending_words.size() > 0 || framed_bytes.size() > 0 || req_push)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_length(logic [63:0] v);
      wait_idle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_STREAM_LENGTH;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      stream_len = v[39:0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic add_data(int n);
      req_type w;
      repeat (n) begin
         w.operation = OP_DATA;
         w.data_byte = 8'($urandom);
         pending_words.push_back(w);
      end
   endtask

   task automatic add_byte(logic [7:0] b);
      req_type w;
      w.operation = OP_DATA;
      w.data_byte = b;
      pending_words.push_back(w);
   endtask

   task automatic add_end();
      req_type w;
      w.operation = OP_END;
      w.data_byte = 8'($urandom);
      pending_words.push_back(w);
   endtask

   initial begin
      int sent;
      int len;
      int n;
      errors = 0;
      cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      stream_len = '0;
      clear_stream();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty stream, then a dropped first byte
      add_end();
      add_byte(8'h00);
      add_end();
      write_length(64'd1);
      add_byte(8'h00);
      add_end();
      write_length(64'd3);
      add_byte(8'hff);
      add_byte(8'h55);
      add_byte(8'haa);
      add_end();
      // surplus bytes, short stream
      write_length(64'd2);
      add_data(3);
      add_end();
      write_length(64'd5);
      add_data(2);
      add_end();
      write_length(64'hffff_ffff_ffff_ffff);
      add_data(1);
      add_end();
      write_length(64'h55_5555_5555);
      add_data(2);
      add_end();
      // length changed inside an open stream
      write_length(64'd3);
      add_data(2);
      write_length(64'd1);
      add_data(1);
      add_end();

      sent = 0;
      while (sent < 440) begin
         if (sent < 160) begin
            send_idle_pct = 22;
            recv_idle_pct = 50;
         end else if (sent < 320) begin
            send_idle_pct = 50;
            recv_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         len = $urandom_range(19) == 0 ? 0 : $urandom_range(1, 20);
         write_length(($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'(len));
         if ($urandom_range(3) == 0) n = len + $urandom_range(6) - 3;
         else n = len;
         if (n < 0) n = 0;
         add_data(n);
         if ($urandom_range(9) != 0) add_end();
         sent += n + 1;
      end
      write_length(64'haa_aaaa_aaaa);
      add_data(3);
      add_end();

      wait_idle();
      if (errors == 0) begin
         $display("tb_xz_stored_stream_framer_core: done, clean");
      end else begin
         $display("tb_xz_stored_stream_framer_core: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/xzf_pkg.sv
src/xzf_front.sv
src/xzf_queue.sv
src/xzf_back.sv
src/xz_stored_stream_framer_core.sv
src/xzf_checker.sv
tb/sv/tb_xz_stored_stream_framer_core.sv
